FILE: hdl/kmx_pkg.sv
// Shared types and constants for the key-mixed XOR stream cipher.
`timescale 1ns / 1ps

package kmx_pkg;

   // Field widths
   localparam int LEN_W    = 9;
   localparam int ROUNDS_W = 10;

   // Item commands
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_PROCESS = 1'b1;

   // Register indexes, taken from address bit 2
   localparam logic REG_KEY_LENGTH = 1'b0;
   localparam logic REG_MIX_ROUNDS = 1'b1;

   // Result status codes
   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_NEEDS_SETUP = 1'b1;

   typedef struct packed {
      logic [LEN_W-1:0]    key_length;
      logic [ROUNDS_W-1:0] mix_rounds;
   } kmx_cfg_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       status;
      logic       last_out;
   } kmx_result_type;

endpackage

FILE: hdl/kmx_engine.sv
// Key store memory and round sequencer that builds the mask for each byte.
`timescale 1ns / 1ps

module kmx_engine #(
   parameter int unsigned KEY_DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kmx_pkg::kmx_cfg_type   cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_command,
   input  logic [7:0]             req_key_address,
   input  logic [7:0]             req_key_byte,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last_of_message,
   output logic                   res_valid,
   input  logic                   res_ready,
   output kmx_pkg::kmx_result_type res
);
   import kmx_pkg::*;

   localparam int AW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type           state_ff;
   logic [ROUNDS_W-1:0] issue_left_ff;
   logic                rd_vld_ff;
   logic [LEN_W-1:0]    idx_ff;
   logic [7:0]          mask_ff;
   logic [7:0]          ri_ff;
   logic [7:0]          bc_ff;
   logic [LEN_W-1:0]    pos_ff;
   logic [7:0]          data_ff;
   logic                last_ff;
   logic                bad_ff;

   logic [7:0]          key_mem_ff [KEY_DEPTH];
   logic [7:0]          rd_data_ff;

   logic [LEN_W-1:0]    eff_len;
   logic                accept;
   logic                wr_en;
   logic                rd_en;
   logic                done;
   logic                res_fire;
   logic [LEN_W-1:0]    idx_in;
   logic [LEN_W:0]      pos_inc;
   logic [LEN_W-1:0]    pos_in;
   logic [7:0]          ri_in;

   // Clamp the key length to the store depth
   assign eff_len = (32'(cfg.key_length) > KEY_DEPTH) ? LEN_W'(KEY_DEPTH) : cfg.key_length;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign wr_en     = accept && (req_command == CMD_LOAD)
                      && (32'(req_key_address) < KEY_DEPTH);
   assign rd_en     = (state_ff == ST_RUN) && (issue_left_ff != '0) && (idx_ff < eff_len);
   assign done      = (state_ff == ST_RUN) && (issue_left_ff == '0) && !rd_vld_ff;
   assign res_valid = done;
   assign res_fire  = done && res_ready;

   // Next key index, wrapping at the effective length
   assign idx_in  = ((idx_ff + 1'b1) == eff_len) ? '0 : idx_ff + 1'b1;
   assign pos_inc = {1'b0, pos_ff} + 1'b1;
   assign pos_in  = (pos_inc > {1'b0, eff_len}) ? '0 : pos_inc[LEN_W-1:0];
   assign ri_in   = ri_ff + 8'd1;

   // Build the result from the finished mask
   assign res.data_out = bad_ff ? 8'd0 : (data_ff ^ mask_ff);
   assign res.status   = bad_ff ? STATUS_NEEDS_SETUP : STATUS_OK;
   assign res.last_out = last_ff;

   // Key store: one write port for loads, one registered read port for rounds
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[AW'(req_key_address)] <= req_key_byte;
      end
      if (rd_en) begin
         rd_data_ff <= key_mem_ff[AW'(idx_ff)];
      end
   end

   // Sequencer: issue one key read per round, fold the returned byte into the mask
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_left_ff <= '0;
         rd_vld_ff     <= 1'b0;
         ri_ff         <= '0;
         bc_ff         <= '0;
         pos_ff        <= '0;
      end else begin
         rd_vld_ff <= rd_en;
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_command == CMD_PROCESS)) begin
                  issue_left_ff <= (eff_len == '0) ? '0 : cfg.mix_rounds;
                  idx_ff        <= (pos_ff == eff_len) ? '0 : pos_ff;
                  mask_ff       <= '0;
                  data_ff       <= req_data_byte;
                  last_ff       <= req_last_of_message;
                  bad_ff        <= (eff_len == '0);
                  state_ff      <= ST_RUN;
               end
            end
            ST_RUN: begin
               // Reduce a start index left beyond a shortened key, one step a cycle
               if ((idx_ff >= eff_len) && (eff_len != '0)) begin
                  idx_ff <= idx_ff - eff_len;
               end else if (rd_en) begin
                  issue_left_ff <= issue_left_ff - 1'b1;
                  idx_ff        <= idx_in;
               end
               if (rd_vld_ff) begin
                  mask_ff <= mask_ff ^ (bc_ff + ri_in - rd_data_ff);
                  ri_ff   <= ri_in;
               end
               // Advance or clear the message counters as the result leaves
               if (res_fire) begin
                  state_ff <= ST_IDLE;
                  if (last_ff) begin
                     ri_ff  <= '0;
                     bc_ff  <= '0;
                     pos_ff <= '0;
                  end else if (!bad_ff) begin
                     bc_ff  <= bc_ff + 8'd1;
                     pos_ff <= pos_in;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Every key read stays inside the loaded key
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (idx_ff < eff_len))
      else $error("key index outside effective length");

   // A byte without key setup never touches the key store
   a_bad_no_reads: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && bad_ff) |-> ((issue_left_ff == '0) && !rd_vld_ff))
      else $error("reads issued while key not set up");

   // Returned key data always follows an issued read
   a_rd_follows: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(rd_en))
      else $error("read data flagged without a read");

endmodule

FILE: hdl/key_mixed_xor_stream_cipher.sv
// Top level of the key-mixed XOR stream cipher: register port and result register.
`timescale 1ns / 1ps

// Usage
//   req_*  : input items. A load item (command 0) writes key_byte to the key
//            store at key_address; it gives no result. A process item
//            (command 1) XORs data_byte with a mask built from the key.
//   rsp_*  : one result item per process item: data_out, status, last_out.
//   psel.. : register port; key_length at 0x0, mix_rounds at 0x4. Write only
//            while no item is in flight.
// Timing
//   A load item leaves the block ready for the next item. A process item
//   holds off the next acceptance until its result enters the result register,
//   paced by the single read port of the key store (one key byte per cycle once
//   the start index is reduced); its result is registered once all mix_rounds
//   key bytes are folded in. With key_length or mix_rounds zero no key is read.
//   A key position left beyond a shortened key adds reduction steps first.
// Reset clears the counters, the registers and the result valid flag; the key
// store holds no reset value and must be loaded before use.
// A stalled receiver holds the result; one further item may run up to its
// finish and then waits until the result register empties.

module key_mixed_xor_stream_cipher #(
   parameter int unsigned KEY_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [7:0]  req_key_address,
   input  logic [7:0]  req_key_byte,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_of_message,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_out,
   output logic        rsp_status,
   output logic        rsp_last_out,
   // Register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import kmx_pkg::*;

   kmx_cfg_type    cfg_ff;
   logic           rsp_valid_ff;
   kmx_result_type rsp_result_ff;

   logic           csr_wr;
   logic           res_valid;
   logic           res_ready;
   kmx_result_type res;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr) begin
         case (paddr[2])
            REG_KEY_LENGTH: cfg_ff.key_length <= pwdata[LEN_W-1:0];
            REG_MIX_ROUNDS: cfg_ff.mix_rounds <= pwdata[ROUNDS_W-1:0];
            default: ;
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (paddr[2])
         REG_KEY_LENGTH: prdata = 32'(cfg_ff.key_length);
         REG_MIX_ROUNDS: prdata = 32'(cfg_ff.mix_rounds);
         default:        prdata = '0;
      endcase
   end

   kmx_engine #(
      .KEY_DEPTH (KEY_DEPTH)
   ) u_engine (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_key_address     (req_key_address),
      .req_key_byte        (req_key_byte),
      .req_data_byte       (req_data_byte),
      .req_last_of_message (req_last_of_message),
      .res_valid           (res_valid),
      .res_ready           (res_ready),
      .res                 (res)
   );

   // Result register: load when empty or draining, hold while stalled
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_result_ff <= res;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_result_ff.data_out;
   assign rsp_status   = rsp_result_ff.status;
   assign rsp_last_out = rsp_result_ff.last_out;

endmodule
